### src/lad_pkg.sv
// Shared definitions for the linear array deque: operation and status codes,
// and the command and status structs between the controller and the datapath.
// Has no dependencies; every other file refers to it by scoped names.
`default_nettype none

package lad_pkg;

    // Operation codes carried by the func field of a request.
    localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [1:0] OP_POP_FRONT  = 2'd1;
    localparam logic [1:0] OP_PUSH_REAR  = 2'd2;
    localparam logic [1:0] OP_POP_REAR   = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_OVF_FRONT = 2'd2;
    localparam logic [1:0] ST_OVF_REAR  = 2'd3;

    // Width of the result data field.
    localparam int unsigned OUT_WIDTH = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // a request is taken this cycle
        logic load_read;  // capture the registered slot read into the result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_read;  // the offered request is a pop of a stored element
    } t_dp_sts;

endpackage

`default_nettype wire

### src/lad_ctrl.sv
// Controller state machine of the linear array deque: sequences one request
// from acceptance through an optional slot read to result delivery.
// Depends on lad_pkg for the command and status structs.
`default_nettype none

module lad_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    output logic                  o_valid,
    input  wire logic             i_stall,
    input  wire lad_pkg::t_dp_sts i_sts,
    output lad_pkg::t_dp_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // The block takes a request only when no earlier one is in flight.
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd.accept    = (r_state == S_IDLE) && i_valid;
        o_cmd.load_read = (r_state == S_READ);
    end

    // Next state: pops of a stored element pass through the read state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = i_sts.need_read ? S_READ : S_OUT;
                end
            end
            S_READ: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### src/lad_dp.sv
// Datapath of the linear array deque: front and rear indices, empty flag,
// slot memory with registered read, and the result registers.
// Depends on lad_pkg for codes and the command and status structs.
`default_nettype none

module lad_dp #(
    parameter int unsigned DEPTH      = 32,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lad_pkg::t_dp_cmd   i_cmd,
    output lad_pkg::t_dp_sts        o_sts,
    input  wire logic [1:0]         i_func,
    input  wire logic signed [31:0] i_push_value,
    output logic signed [31:0]      o_pop_value,
    output logic [1:0]              o_status
);

    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    logic [IW-1:0] r_front;
    logic [IW-1:0] n_front;
    logic [IW-1:0] r_rear;
    logic [IW-1:0] n_rear;
    logic          r_empty;
    logic          n_empty;

    logic signed [31:0] r_pop_value;
    logic signed [31:0] n_pop_value;
    logic [1:0]         r_status;
    logic [1:0]         n_status;

    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [IW-1:0]         rd_addr;
    logic                  rd_en;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [63:0]           rd_wide;

    assign wr_data = DATA_WIDTH'($unsigned(i_push_value));

    // Stored value sign-extended from its width, then cut to the result width.
    assign rd_wide = 64'(signed'(r_rd_data));

    assign o_sts.need_read = !r_empty &&
        ((i_func == lad_pkg::OP_POP_FRONT) || (i_func == lad_pkg::OP_POP_REAR));

    assign o_pop_value = r_pop_value;
    assign o_status    = r_status;

    // Decode the offered request against the current indices.
    always_comb begin
        n_front     = r_front;
        n_rear      = r_rear;
        n_empty     = r_empty;
        n_pop_value = r_pop_value;
        n_status    = r_status;
        wr_en       = 1'b0;
        wr_addr     = '0;
        rd_en       = 1'b0;
        rd_addr     = r_front;
        if (i_cmd.accept) begin
            n_pop_value = '0;
            n_status    = lad_pkg::ST_OK;
            case (i_func)
                lad_pkg::OP_PUSH_FRONT: begin
                    if (r_empty) begin
                        n_empty = 1'b0;
                        n_front = '0;
                        n_rear  = '0;
                        wr_en   = 1'b1;
                    end else if (r_front != '0) begin
                        n_front = r_front - 1'b1;
                        wr_addr = r_front - 1'b1;
                        wr_en   = 1'b1;
                    end else begin
                        n_status = lad_pkg::ST_OVF_FRONT;
                    end
                end
                lad_pkg::OP_PUSH_REAR: begin
                    if (r_empty) begin
                        n_empty = 1'b0;
                        n_front = '0;
                        n_rear  = '0;
                        wr_en   = 1'b1;
                    end else if (r_rear != LAST) begin
                        n_rear  = r_rear + 1'b1;
                        wr_addr = r_rear + 1'b1;
                        wr_en   = 1'b1;
                    end else begin
                        n_status = lad_pkg::ST_OVF_REAR;
                    end
                end
                lad_pkg::OP_POP_FRONT: begin
                    if (r_empty) begin
                        n_pop_value = '1;
                        n_status    = lad_pkg::ST_EMPTY;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_front;
                        if (r_front == r_rear) begin
                            n_empty = 1'b1;
                            n_front = '0;
                            n_rear  = '0;
                        end else begin
                            n_front = r_front + 1'b1;
                        end
                    end
                end
                default: begin
                    if (r_empty) begin
                        n_pop_value = '1;
                        n_status    = lad_pkg::ST_EMPTY;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_rear;
                        if (r_front == r_rear) begin
                            n_empty = 1'b1;
                            n_front = '0;
                            n_rear  = '0;
                        end else begin
                            n_rear = r_rear - 1'b1;
                        end
                    end
                end
            endcase
        end else if (i_cmd.load_read) begin
            n_pop_value = signed'(rd_wide[lad_pkg::OUT_WIDTH-1:0]);
        end
    end

    // Slot memory: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Indices and empty flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_rear  <= '0;
            r_empty <= 1'b1;
        end else begin
            r_front <= n_front;
            r_rear  <= n_rear;
            r_empty <= n_empty;
        end
    end

    // Result registers hold their value while the result waits.
    always_ff @(posedge i_clk) begin
        r_pop_value <= n_pop_value;
        r_status    <= n_status;
    end

endmodule

`default_nettype wire

### src/linear_array_deque_core.sv
// Linear array deque: push and pop at either end of a non-circular slot array.
// A push or a pop on an empty deque shows its result in the cycle after
// acceptance; a pop of a stored element first takes the registered memory
// read into the result register. One request is in flight at a time, so a
// new request is taken the cycle after its predecessor's result is delivered.
// Reset (synchronous, active low) empties the deque; slot contents are kept.
`default_nettype none

module linear_array_deque_core #(
    parameter int unsigned DEPTH      = 32,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_func,
    input  wire logic signed [31:0] i_push_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_pop_value,
    output logic [1:0]              o_status
);

    lad_pkg::t_dp_cmd cmd;
    lad_pkg::t_dp_sts sts;

    // Request sequencing.
    lad_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Indices, slot memory and result registers.
    lad_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_func       (i_func),
        .i_push_value (i_push_value),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status)
    );

endmodule

`default_nettype wire

### tb/tb_linear_array_deque_core.sv
// Self-checking testbench for linear_array_deque_core: directed corner cases, then
// random bursts of deque requests under three idling patterns on both channels.
// Depends on lad_pkg for the operation and status codes and on the core module.
module tb_linear_array_deque_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 32;
    localparam int CYCLE_LIMIT = 200000;

    // One result as the core reports it.
    typedef struct {
        logic signed [31:0] pop_value;
        logic [1:0]         status;
    } t_deque_result;

    // Mirror of the deque contents, and the queue of results still owed by the core.
    class deque_scoreboard;
        logic signed [31:0] slots [DEPTH];
        logic [4:0]         front_idx;
        logic [4:0]         rear_idx;
        logic               is_empty;
        t_deque_result      owed_results [$];
        int                 errors;
        int                 requests_noted;
        int                 results_checked;
        int                 status_seen [4];

        function new();
            front_idx = '0;
            rear_idx  = '0;
            is_empty  = 1'b1;
            errors    = 0;
            requests_noted  = 0;
            results_checked = 0;
            foreach (slots[i]) slots[i] = '0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // Applies one operation to the mirror and returns the result it must give.
        function t_deque_result apply_operation(logic [1:0] func, logic signed [31:0] value);
            t_deque_result res;
            logic [4:0]    idx;
            res.pop_value = '0;
            res.status    = lad_pkg::ST_OK;
            case (func)
                lad_pkg::OP_PUSH_FRONT, lad_pkg::OP_PUSH_REAR: begin
                    if (is_empty) begin
                        // Either push on an empty deque lands in slot 0.
                        is_empty  = 1'b0;
                        front_idx = '0;
                        rear_idx  = '0;
                        slots[0]  = value;
                    end else if (func == lad_pkg::OP_PUSH_FRONT) begin
                        if (front_idx != '0) begin
                            front_idx = front_idx - 5'd1;
                            slots[front_idx] = value;
                        end else begin
                            res.status = lad_pkg::ST_OVF_FRONT;
                        end
                    end else begin
                        if (rear_idx != 5'(DEPTH - 1)) begin
                            rear_idx = rear_idx + 5'd1;
                            slots[rear_idx] = value;
                        end else begin
                            res.status = lad_pkg::ST_OVF_REAR;
                        end
                    end
                end
                default: begin
                    if (is_empty) begin
                        res.pop_value = -32'sd1;
                        res.status    = lad_pkg::ST_EMPTY;
                    end else begin
                        idx = (func == lad_pkg::OP_POP_FRONT) ? front_idx : rear_idx;
                        res.pop_value = slots[idx];
                        // Removing the last element returns both indices to zero.
                        if (front_idx == rear_idx) begin
                            is_empty  = 1'b1;
                            front_idx = '0;
                            rear_idx  = '0;
                        end else if (func == lad_pkg::OP_POP_FRONT) begin
                            front_idx = front_idx + 5'd1;
                        end else begin
                            rear_idx = rear_idx - 5'd1;
                        end
                    end
                end
            endcase
            return res;
        endfunction

        function void note_request(logic [1:0] func, logic signed [31:0] value);
            owed_results.push_back(apply_operation(func, value));
            requests_noted++;
        endfunction

        function void check_result(logic signed [31:0] pop_value, logic [1:0] status);
            t_deque_result want;
            if (owed_results.size() == 0) begin
                $display("%0t: result with no request waiting: pop_value %0d status %0d",
                         $time, pop_value, status);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            results_checked++;
            status_seen[status]++;
            if (pop_value !== want.pop_value) begin
                $display("%0t: pop_value mismatch: expected %0d actual %0d",
                         $time, want.pop_value, pop_value);
                errors++;
            end
            if (status !== want.status) begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, want.status, status);
                errors++;
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_func = lad_pkg::OP_PUSH_FRONT;
    logic signed [31:0] i_push_value = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_pop_value;
    logic [1:0]         o_status;

    int send_idle_pct = 27;
    int recv_stall_pct = 73;
    int cycle_count = 0;

    deque_scoreboard sb = new();

    linear_array_deque_core #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (32)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status)
    );

    // Free-running clock.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Watch both channels: note each accepted request and check each accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_request(i_func, i_push_value);
            if (o_valid && !i_stall) sb.check_result(o_pop_value, o_status);
        end
    end

    // Result side back-pressure.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Guard against a hung core.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offers one request, idling first at random, and returns at its acceptance edge.
    task automatic send_request(input logic [1:0] func, input logic signed [31:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_func       <= func;
        i_push_value <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(15))
            0:       v = 32'sh7FFF_FFFF;
            1:       v = 32'sh8000_0000;
            2:       v = -32'sd1;
            3:       v = '0;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Short directed sequence over the empty, overflow and last-element cases.
    task automatic run_directed();
        send_request(lad_pkg::OP_POP_FRONT,  32'sd5);
        send_request(lad_pkg::OP_POP_REAR,   -32'sd7);
        send_request(lad_pkg::OP_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_request(lad_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
        send_request(lad_pkg::OP_PUSH_REAR,  -32'sd1);
        send_request(lad_pkg::OP_PUSH_REAR,  32'sd0);
        send_request(lad_pkg::OP_POP_FRONT,  32'sd0);
        send_request(lad_pkg::OP_PUSH_FRONT, 32'sh1234_5678);
        send_request(lad_pkg::OP_PUSH_FRONT, 32'sh0BAD_F00D);
        send_request(lad_pkg::OP_POP_REAR,   32'sd0);
        send_request(lad_pkg::OP_POP_REAR,   32'sd0);
        send_request(lad_pkg::OP_POP_REAR,   32'sd0);
        send_request(lad_pkg::OP_POP_FRONT,  32'sh7FFF_FFFF);
        send_request(lad_pkg::OP_PUSH_REAR,  32'sh8000_0000);
        send_request(lad_pkg::OP_POP_FRONT,  32'sd0);
        send_request(lad_pkg::OP_PUSH_REAR,  32'sh5555_5555);
        send_request(lad_pkg::OP_PUSH_REAR,  32'shAAAA_AAAA);
        send_request(lad_pkg::OP_POP_FRONT,  32'sd0);
        send_request(lad_pkg::OP_POP_FRONT,  32'sd0);
        send_request(lad_pkg::OP_POP_REAR,   32'sd0);
    endtask

    // Random bursts, each biased towards filling, draining or mixing the deque.
    task automatic run_random(input int count);
        int         sent;
        int         burst_len;
        int         mode;
        int         roll;
        logic [1:0] func;
        sent = 0;
        while (sent < count) begin
            mode      = $urandom_range(3);
            burst_len = $urandom_range(60, 8);
            for (int k = 0; k < burst_len && sent < count; k++) begin
                roll = $urandom_range(99);
                case (mode)
                    // Mostly rear pushes, to reach the last slot.
                    0: func = (roll < 90) ? lad_pkg::OP_PUSH_REAR : 2'($urandom_range(3));
                    // Front pops opening space below the front, then front pushes.
                    1: func = (roll < 55) ? lad_pkg::OP_POP_FRONT :
                              (roll < 85) ? lad_pkg::OP_PUSH_FRONT : 2'($urandom_range(3));
                    // Drain from both ends, down to empty pops.
                    2: func = (roll < 40) ? lad_pkg::OP_POP_REAR :
                              (roll < 80) ? lad_pkg::OP_POP_FRONT : 2'($urandom_range(3));
                    default: func = 2'($urandom_range(3));
                endcase
                send_request(func, pick_value());
                sent++;
            end
        end
    endtask

    // Main sequence: reset, directed part, three idling phases, drain and report.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random(400);
        send_idle_pct = 73;
        recv_stall_pct <= 27;
        run_random(400);
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        run_random(400);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.errors++;
        end
        $display("Covered %0d requests, %0d results checked in %0d cycles.",
                 sb.requests_noted, sb.results_checked, cycle_count);
        $display("Results by status: ok %0d, empty %0d, front overflow %0d, rear overflow %0d.",
                 sb.status_seen[lad_pkg::ST_OK],
                 sb.status_seen[lad_pkg::ST_EMPTY],
                 sb.status_seen[lad_pkg::ST_OVF_FRONT],
                 sb.status_seen[lad_pkg::ST_OVF_REAR]);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
